/* rtl/twla_pkg.sv */
// Shared types, constants and codes for the time-weighted level average block.
`default_nettype none

package twla_pkg;

	localparam int MAX_LEVEL = 10000;
	localparam int LEVEL_IN_W = 16;
	localparam int LEVEL_W = $clog2(MAX_LEVEL + 1);
	localparam int WORD_W = 64;
	localparam int CNT_W = $clog2(WORD_W);

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_OFF   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPAN,
		ST_MUL,
		ST_ACC_ON,
		ST_ACC_LT,
		ST_CHECK,
		ST_DIV,
		ST_SAT,
		ST_DONE
	} state_t;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] sum;
		logic              carry;
	} alu_rsp_t;

endpackage

`default_nettype wire

/* rtl/twla_alu.sv */
// Shared 64-bit add/subtract unit; carry out high on a subtract means a >= b.
`default_nettype none

module twla_alu (
	input  wire twla_pkg::alu_req_t req,
	output twla_pkg::alu_rsp_t      rsp
);

	logic [twla_pkg::WORD_W:0] full;

	always_comb begin
		full = {1'b0, req.a} + {1'b0, req.b ^ {twla_pkg::WORD_W{req.sub}}}
			+ {{twla_pkg::WORD_W{1'b0}}, req.sub};
		rsp.sum = full[twla_pkg::WORD_W-1:0];
		rsp.carry = full[twla_pkg::WORD_W];
	end

endmodule

`default_nettype wire

/* rtl/time_weighted_level_average.sv */
// Top level: sequencer, state registers and output register of the level averager.
// From accept to out_valid: a rejected update goes straight to the output; an accepted
//   beat with a dark held level skips the multiply, else does one shift-add step per bit of it.
// A read with nonzero sums adds 64 restoring-division steps, a clamp and output waits.
// Throughput: in_ready is high only while the sequencer idles; the output register lets
//   the next beat enter while a result still waits. Reset clears the sequencer, the held state and out_valid.
`default_nettype none

module time_weighted_level_average (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration write channel
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire                                    cfg_data,
	// input channel
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire                                    operation,
	input  wire  [twla_pkg::LEVEL_IN_W-1:0]        level,
	input  wire  [twla_pkg::WORD_W-1:0]            timestamp_ms,
	// result channel
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic [1:0]                             status,
	output logic [twla_pkg::LEVEL_W-1:0]           average_level
);

	twla_pkg::state_t state_q, state_d;

	// architectural state
	logic                              enable_q;
	logic [twla_pkg::WORD_W-1:0]       prior_time_q;
	logic [twla_pkg::LEVEL_W-1:0]      held_level_q;
	logic [twla_pkg::WORD_W-1:0]       on_sum_q;
	logic [twla_pkg::WORD_W-1:0]       lt_sum_q;

	// working registers of the current beat
	twla_pkg::op_t                     op_q;
	logic [twla_pkg::LEVEL_W-1:0]      new_level_q;
	logic [twla_pkg::WORD_W-1:0]       now_q;
	logic [twla_pkg::WORD_W-1:0]       span_q;
	logic [twla_pkg::WORD_W-1:0]       mcand_q;
	logic [twla_pkg::LEVEL_W-1:0]      mbits_q;
	logic [twla_pkg::WORD_W-1:0]       prod_q;
	logic [twla_pkg::WORD_W-1:0]       rem_q;
	logic [twla_pkg::WORD_W-1:0]       quot_q;
	logic [twla_pkg::CNT_W-1:0]        cnt_q;
	twla_pkg::status_t                 res_status_q;
	logic [twla_pkg::LEVEL_W-1:0]      res_avg_q;

	// output register
	logic                              out_valid_q;
	twla_pkg::status_t                 status_q;
	logic [twla_pkg::LEVEL_W-1:0]      avg_q;

	twla_pkg::alu_req_t                alu_req;
	twla_pkg::alu_rsp_t                alu_rsp;

	logic                              in_fire;
	logic                              rejected;
	logic                              out_load;
	logic                              div_take;
	logic [twla_pkg::WORD_W-1:0]       div_shift;
	logic                              sums_zero;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == twla_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	// an update is turned away while disabled or when the level is out of range
	assign rejected = (operation == twla_pkg::OP_UPDATE)
		&& (!enable_q || (level > twla_pkg::LEVEL_IN_W'(twla_pkg::MAX_LEVEL)));
	assign out_load = !out_valid_q || out_ready;
	assign sums_zero = (on_sum_q == '0) || (lt_sum_q == '0);

	// restoring division: shift the next dividend bit into the remainder
	assign div_shift = {rem_q[twla_pkg::WORD_W-2:0], quot_q[twla_pkg::WORD_W-1]};
	assign div_take = rem_q[twla_pkg::WORD_W-1] || alu_rsp.carry;

	twla_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			twla_pkg::ST_IDLE: begin
				if (in_fire) state_d = rejected ? twla_pkg::ST_DONE : twla_pkg::ST_SPAN;
			end
			twla_pkg::ST_SPAN: begin
				// a zero held level adds nothing to either sum
				state_d = (held_level_q == '0) ? twla_pkg::ST_CHECK : twla_pkg::ST_MUL;
			end
			twla_pkg::ST_MUL: begin
				if ((mbits_q >> 1) == '0) state_d = twla_pkg::ST_ACC_ON;
			end
			twla_pkg::ST_ACC_ON: state_d = twla_pkg::ST_ACC_LT;
			twla_pkg::ST_ACC_LT: state_d = twla_pkg::ST_CHECK;
			twla_pkg::ST_CHECK: begin
				if (op_q == twla_pkg::OP_UPDATE || sums_zero) state_d = twla_pkg::ST_DONE;
				else state_d = twla_pkg::ST_DIV;
			end
			twla_pkg::ST_DIV: begin
				if (cnt_q == twla_pkg::CNT_W'(twla_pkg::WORD_W - 1)) state_d = twla_pkg::ST_SAT;
			end
			twla_pkg::ST_SAT: state_d = twla_pkg::ST_DONE;
			twla_pkg::ST_DONE: begin
				if (out_load) state_d = twla_pkg::ST_IDLE;
			end
			default: state_d = twla_pkg::ST_IDLE;
		endcase
	end

	// shared unit operand selection
	always_comb begin
		alu_req = '0;
		case (state_q)
			twla_pkg::ST_SPAN: begin
				alu_req.a = now_q;
				alu_req.b = prior_time_q;
				alu_req.sub = 1'b1;
			end
			twla_pkg::ST_MUL: begin
				alu_req.a = prod_q;
				alu_req.b = mcand_q;
			end
			twla_pkg::ST_ACC_ON: begin
				alu_req.a = on_sum_q;
				alu_req.b = span_q;
			end
			twla_pkg::ST_ACC_LT: begin
				alu_req.a = lt_sum_q;
				alu_req.b = prod_q;
			end
			twla_pkg::ST_DIV: begin
				alu_req.a = div_shift;
				alu_req.b = on_sum_q;
				alu_req.sub = 1'b1;
			end
			default: alu_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twla_pkg::ST_IDLE;
			enable_q <= 1'b0;
			prior_time_q <= '0;
			held_level_q <= '0;
			on_sum_q <= '0;
			lt_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) enable_q <= cfg_data;

			case (state_q)
				twla_pkg::ST_SPAN: begin
					// close the interval, hold the new time and, on an update, the new level
					prior_time_q <= now_q;
					if (op_q == twla_pkg::OP_UPDATE) held_level_q <= new_level_q;
				end
				twla_pkg::ST_ACC_ON: on_sum_q <= alu_rsp.sum;
				twla_pkg::ST_ACC_LT: lt_sum_q <= alu_rsp.sum;
				twla_pkg::ST_CHECK: begin
					if (op_q == twla_pkg::OP_READ && sums_zero) begin
						on_sum_q <= '0;
						lt_sum_q <= '0;
					end
				end
				twla_pkg::ST_SAT: begin
					on_sum_q <= '0;
					lt_sum_q <= '0;
				end
				default: ;
			endcase

			// output register: drop valid on take, load when free
			if (state_q == twla_pkg::ST_DONE && out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			twla_pkg::ST_IDLE: begin
				if (in_fire) begin
					op_q <= twla_pkg::op_t'(operation);
					new_level_q <= level[twla_pkg::LEVEL_W-1:0];
					now_q <= timestamp_ms;
					res_avg_q <= '0;
					// reads are never gated by the enable
					if (rejected && !enable_q) res_status_q <= twla_pkg::STATUS_OFF;
					else if (rejected) res_status_q <= twla_pkg::STATUS_RANGE;
					else res_status_q <= twla_pkg::STATUS_OK;
				end
			end
			twla_pkg::ST_SPAN: begin
				span_q <= alu_rsp.sum;
				mcand_q <= alu_rsp.sum;
				mbits_q <= held_level_q;
				prod_q <= '0;
			end
			twla_pkg::ST_MUL: begin
				// add the shifted multiplicand for each set bit, low bit first
				if (mbits_q[0]) prod_q <= alu_rsp.sum;
				mcand_q <= mcand_q << 1;
				mbits_q <= mbits_q >> 1;
			end
			twla_pkg::ST_CHECK: begin
				rem_q <= '0;
				quot_q <= lt_sum_q;
				cnt_q <= '0;
			end
			twla_pkg::ST_DIV: begin
				rem_q <= div_take ? alu_rsp.sum : div_shift;
				quot_q <= {quot_q[twla_pkg::WORD_W-2:0], div_take};
				cnt_q <= cnt_q + 1'b1;
			end
			twla_pkg::ST_SAT: begin
				// clamp an average pushed past the maximum by wrapped sums
				if (quot_q > twla_pkg::WORD_W'(twla_pkg::MAX_LEVEL))
					res_avg_q <= twla_pkg::LEVEL_W'(twla_pkg::MAX_LEVEL);
				else
					res_avg_q <= quot_q[twla_pkg::LEVEL_W-1:0];
			end
			twla_pkg::ST_DONE: begin
				if (out_load) begin
					status_q <= res_status_q;
					avg_q <= res_avg_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign average_level = avg_q;

endmodule

`default_nettype wire

/* rtl/twla_checker.sv */
// Port-level checker for the level averager and its bind to the top level.
`default_nettype none

module twla_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire [1:0]                          status,
	input wire [twla_pkg::LEVEL_W-1:0]        average_level
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(average_level))
		else $error("result beat changed while stalled");

	// one beat in flight: the block is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted in back-to-back cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == twla_pkg::STATUS_OK || status == twla_pkg::STATUS_RANGE
			|| status == twla_pkg::STATUS_OFF)
		else $error("undefined status code");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != twla_pkg::STATUS_OK |-> average_level == '0)
		else $error("rejected update carries a nonzero average");

	a_avg_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> average_level <= twla_pkg::LEVEL_W'(twla_pkg::MAX_LEVEL))
		else $error("average above maximum level");

endmodule

bind time_weighted_level_average twla_checker u_twla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.average_level (average_level)
);

`default_nettype wire

/* tb/sv/time_weighted_level_average_tb.sv */
// Self-checking testbench for the time-weighted level average block.
module time_weighted_level_average_tb;
	import twla_pkg::*;

	// One result beat as the predictor expects it.
	typedef struct packed {
		status_t              status;
		logic [LEVEL_W-1:0]   average;
	} level_result_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   cfg_valid    = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data     = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	op_t                    operation    = OP_UPDATE;
	logic [LEVEL_IN_W-1:0]  level        = '0;
	logic [WORD_W-1:0]      timestamp_ms = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic [1:0]             status;
	logic [LEVEL_W-1:0]     average_level;

	// Predictor copy of the block state and its one register.
	logic                   track_on;
	logic [WORD_W-1:0]      prior_stamp;
	logic [LEVEL_W-1:0]     held_lvl;
	logic [WORD_W-1:0]      on_time_acc;
	logic [WORD_W-1:0]      level_time_acc;

	// Results still owed by the block, oldest first.
	level_result_t          owed_results[$];

	int errors           = 0;
	int items_sent       = 0;
	int reads_sent       = 0;
	int updates_taken    = 0;
	int updates_rejected = 0;
	int updates_ignored  = 0;
	int reads_saturated  = 0;
	int results_checked  = 0;

	// Idle limits for each side, and a one-shot request for a long receiver hold-off.
	int in_gap_max       = 15;
	int out_stall_max    = 15;
	int hold_off_request = 0;

	// Running millisecond clock for the random traffic.
	logic [WORD_W-1:0]      clock_ms;

	time_weighted_level_average uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.level         (level),
		.timestamp_ms  (timestamp_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.average_level (average_level)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Close the interval up to now; only a lit interval feeds the sums.
	function automatic void fold_interval(input logic [WORD_W-1:0] now,
			input logic [LEVEL_W-1:0] next_lvl);
		logic [WORD_W-1:0] span;
		logic [WORD_W-1:0] held_wide;
		if (held_lvl != '0) begin
			span = now - prior_stamp;
			held_wide = {{(WORD_W-LEVEL_W){1'b0}}, held_lvl};
			on_time_acc = on_time_acc + span;
			level_time_acc = level_time_acc + held_wide * span;
		end
		prior_stamp = now;
		held_lvl = next_lvl;
	endfunction

	// Advance the predictor by one accepted item and return the result it owes.
	function automatic level_result_t predict_average(input op_t op,
			input logic [LEVEL_IN_W-1:0] lvl, input logic [WORD_W-1:0] now);
		level_result_t r;
		logic [WORD_W-1:0] quot;
		r.status = STATUS_OK;
		r.average = '0;
		if (op == OP_UPDATE) begin
			if (!track_on) begin
				r.status = STATUS_OFF;
			end else if (lvl > MAX_LEVEL) begin
				r.status = STATUS_RANGE;
			end else begin
				fold_interval(now, lvl[LEVEL_W-1:0]);
			end
		end else begin
			fold_interval(now, held_lvl);
			if (on_time_acc != '0 && level_time_acc != '0) begin
				quot = level_time_acc / on_time_acc;
				// wrapped sums can push the quotient past full scale: clamp it
				if (quot > MAX_LEVEL)
					quot = WORD_W'(MAX_LEVEL);
				r.average = quot[LEVEL_W-1:0];
			end
			on_time_acc = '0;
			level_time_acc = '0;
		end
		return r;
	endfunction

	// Offer one input beat after a random gap, hold it until accepted, then predict.
	// Valid stays high on return so that a zero gap on the next beat needs no toggle.
	task automatic send_item(input op_t op, input logic [LEVEL_IN_W-1:0] lvl,
			input logic [WORD_W-1:0] now);
		int gap;
		level_result_t r;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		level        <= lvl;
		timestamp_ms <= now;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_average(op, lvl, now);
		owed_results.push_back(r);
		items_sent++;
		if (op == OP_READ) begin
			reads_sent++;
			if (r.average == MAX_LEVEL)
				reads_saturated++;
		end else if (r.status == STATUS_OK) begin
			updates_taken++;
		end else if (r.status == STATUS_RANGE) begin
			updates_rejected++;
		end else begin
			updates_ignored++;
		end
	endtask

	// Drop valid and hold the sender until every owed result has come back.
	task automatic wait_for_results;
		in_valid <= 1'b0;
		do @(posedge clk); while (owed_results.size() != 0);
	endtask

	// Write the enable register with the block idle.
	task automatic write_tracking_enable(input logic value);
		wait_for_results();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		track_on = value;
	endtask

	// Result side: check every accepted beat against the oldest expectation, then
	// draw a fresh stall. A pending hold-off request overrides the stall.
	initial begin : result_checker
		int stall_left;
		int hold_left;
		level_result_t want;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat: expected none, actual status %0d average %0d",
						$time, status, average_level);
				end else begin
					want = owed_results.pop_front();
					results_checked++;
					if (status !== want.status) begin
						errors++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, status);
					end
					if (average_level !== want.average) begin
						errors++;
						$display("%0t: average mismatch: expected %0d, actual %0d",
							$time, want.average, average_level);
					end
				end
				stall_left = $urandom_range(0, out_stall_max);
			end
			if (hold_off_request > 0) begin
				hold_left = hold_off_request;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Updates with tracking off are ignored, even out of range; a read still runs.
	task automatic test_disabled_tracking;
		send_item(OP_UPDATE, 16'd500, 64'd10);
		send_item(OP_UPDATE, 16'hFFFF, 64'd15);
		send_item(OP_READ, 16'hFFFF, 64'd20);
		write_tracking_enable(1'b1);
	endtask

	// Level extremes, out-of-range rejects, dark intervals and empty sums.
	task automatic test_level_limits;
		send_item(OP_UPDATE, 16'd0, 64'd100);
		send_item(OP_UPDATE, LEVEL_IN_W'(MAX_LEVEL), 64'd200);
		send_item(OP_UPDATE, LEVEL_IN_W'(MAX_LEVEL + 1), 64'd250);
		send_item(OP_UPDATE, 16'hFFFF, 64'd260);
		send_item(OP_UPDATE, 16'd1, 64'd1200);
		send_item(OP_READ, 16'd0, 64'd1300);
		// back-to-back read: sums were just cleared
		send_item(OP_READ, 16'hFFFF, 64'd1300);
		send_item(OP_UPDATE, 16'd0, 64'd1400);
		send_item(OP_READ, 16'd0, 64'd5000);
		// held level is zero: nothing accrues, average is zero
		send_item(OP_READ, 16'd0, 64'd9000);
		wait_for_results();
	endtask

	// Build sums whose wrapped ratio lands far above full scale.
	task automatic test_saturation;
		logic [WORD_W-1:0] t0;
		t0 = 64'h0123_4567_89AB_CDEF;
		send_item(OP_UPDATE, LEVEL_IN_W'(MAX_LEVEL), t0);
		send_item(OP_UPDATE, 16'd1, t0 + 64'd1000);
		send_item(OP_READ, 16'd0, t0 + 64'd1);
		wait_for_results();
	endtask

	// Timestamps at both ends of the range and time running backwards.
	task automatic test_time_extremes;
		send_item(OP_UPDATE, 16'd5000, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_UPDATE, 16'd0, 64'd0);
		send_item(OP_READ, 16'd0, 64'd0);
		send_item(OP_UPDATE, 16'd7, 64'd10);
		send_item(OP_UPDATE, 16'd3, 64'd5);
		send_item(OP_READ, 16'd0, 64'd6);
		wait_for_results();
	endtask

	// A read with tracking off still closes the interval and clears the sums.
	task automatic test_read_while_disabled;
		send_item(OP_UPDATE, 16'd400, 64'd1000);
		send_item(OP_UPDATE, 16'd4000, 64'd1030);
		write_tracking_enable(1'b0);
		send_item(OP_UPDATE, 16'd9, 64'd1050);
		send_item(OP_READ, 16'd0, 64'd1090);
		write_tracking_enable(1'b1);
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering beats
	// back to back, so the output register fills and in_ready drops; then pause the
	// sender until everything has drained and push a second burst.
	task automatic test_backpressure;
		int gap_keep;
		int stall_keep;
		gap_keep = in_gap_max;
		stall_keep = out_stall_max;
		wait_for_results();
		in_gap_max = 0;
		hold_off_request = 400;
		for (int i = 0; i < 10; i++) begin
			clock_ms = clock_ms + $urandom_range(1, 500);
			send_item((i % 4 == 3) ? OP_READ : OP_UPDATE,
				(i % 5 == 2) ? 16'hFFFF : 16'($urandom_range(0, MAX_LEVEL)), clock_ms);
		end
		wait_for_results();
		out_stall_max = 0;
		for (int i = 0; i < 6; i++) begin
			clock_ms = clock_ms + $urandom_range(1, 500);
			send_item((i == 5) ? OP_READ : OP_UPDATE,
				16'($urandom_range(0, MAX_LEVEL)), clock_ms);
		end
		wait_for_results();
		in_gap_max = gap_keep;
		out_stall_max = stall_keep;
	endtask

	// Mostly well-formed sessions (forward time, legal levels, occasional reads) with
	// rejects, backward steps and huge jumps mixed in; idling varies per phase.
	task automatic test_random_traffic;
		int pick;
		int count;
		logic enable_now;
		op_t op;
		logic [LEVEL_IN_W-1:0] lvl;
		for (int phase = 0; phase < 8; phase++) begin
			enable_now = (phase == 2 || phase == 5) ? 1'b0 : 1'b1;
			write_tracking_enable(enable_now);
			count = enable_now ? 310 : 60;
			in_gap_max = (phase == 3 || phase == 6) ? 0 : 15;
			out_stall_max = (phase == 3 || phase == 7) ? 0 : 15;
			for (int i = 0; i < count; i++) begin
				pick = $urandom_range(0, 99);
				op = (pick < 17) ? OP_READ : OP_UPDATE;
				pick = $urandom_range(0, 99);
				if (pick < 60)
					lvl = LEVEL_IN_W'($urandom_range(0, MAX_LEVEL));
				else if (pick < 70)
					lvl = LEVEL_IN_W'($urandom_range(0, 15));
				else if (pick < 76)
					lvl = '0;
				else if (pick < 82)
					lvl = LEVEL_IN_W'(MAX_LEVEL);
				else if (pick < 91)
					lvl = LEVEL_IN_W'($urandom_range(MAX_LEVEL + 1, 65535));
				else
					lvl = LEVEL_IN_W'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 75)
					clock_ms = clock_ms + $urandom_range(0, 2000);
				else if (pick < 85)
					clock_ms = clock_ms + $urandom;
				else if (pick < 92)
					clock_ms = clock_ms;
				else if (pick < 96)
					clock_ms = clock_ms - $urandom_range(1, 5000);
				else
					clock_ms = {$urandom, $urandom};
				send_item(op, lvl, clock_ms);
			end
		end
		in_gap_max = 15;
		out_stall_max = 15;
	endtask

	initial begin
		// Mirror the reset state in the predictor.
		track_on = 1'b0;
		prior_stamp = '0;
		held_lvl = '0;
		on_time_acc = '0;
		level_time_acc = '0;
		clock_ms = 64'd5000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_tracking();
		test_level_limits();
		test_saturation();
		test_time_extremes();
		test_read_while_disabled();
		test_backpressure();
		test_random_traffic();

		// Drain, then give the block a read's worth of cycles to show any stray beat.
		wait_for_results();
		repeat (100) @(posedge clk);
		if (owed_results.size() != 0) begin
			errors += owed_results.size();
			$display("%0t: %0d results never arrived", $time, owed_results.size());
		end

		$display("tb: %0d beats (%0d reads, %0d saturated), %0d results checked, %0d errors",
			items_sent, reads_sent, reads_saturated, results_checked, errors);
		$display("tb: updates taken %0d, out of range %0d, ignored while off %0d",
			updates_taken, updates_rejected, updates_ignored);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: well past the slowest legal run.
	initial begin
		#(12 * 1500000);
		$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
rtl/twla_pkg.sv
rtl/twla_alu.sv
rtl/time_weighted_level_average.sv
rtl/twla_checker.sv
tb/sv/time_weighted_level_average_tb.sv
